// File: rtl/spq_pkg.sv
// Package for the stable priority queue: widths, codes and the cell control struct.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps
package spq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int PRIO_W        = 16;
    localparam int TAG_W         = 16;
    localparam int STATUS_W      = 2;
    localparam int OCC_W         = 5;

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic                     enq;
        logic                     deq;
        logic signed [PRIO_W-1:0] prio;
        logic        [TAG_W-1:0]  tag;
    } spq_ctrl_t;

endpackage

// File: rtl/spq_cell.sv
// One slot of the sorted chain: holds a priority and a tag and shifts them
// toward the back on an insert ahead of it or toward the front on a removal.
// Depends on spq_pkg.
`timescale 1ns / 1ps
module spq_cell
    import spq_pkg::*;
(
    input  logic                     clk,
    input  spq_ctrl_t                ctrl,
    input  logic                     occupied,
    input  logic                     left_keep,
    input  logic signed [PRIO_W-1:0] left_prio,
    input  logic        [TAG_W-1:0]  left_tag,
    input  logic signed [PRIO_W-1:0] right_prio,
    input  logic        [TAG_W-1:0]  right_tag,
    output logic                     keep,
    output logic signed [PRIO_W-1:0] prio,
    output logic        [TAG_W-1:0]  tag
);

    logic signed [PRIO_W-1:0] prio_reg;
    logic signed [PRIO_W-1:0] prio_next;
    logic        [TAG_W-1:0]  tag_reg;
    logic        [TAG_W-1:0]  tag_next;

    // An occupied slot whose priority is lower or equal stays ahead of the new item.
    assign keep = occupied && (prio_reg <= ctrl.prio);

    always_comb
    begin
        prio_next = prio_reg;
        tag_next  = tag_reg;
        if (ctrl.enq && !keep)
        begin
            if (left_keep)
            begin
                prio_next = ctrl.prio;
                tag_next  = ctrl.tag;
            end
            else
            begin
                prio_next = left_prio;
                tag_next  = left_tag;
            end
        end
        else if (ctrl.deq)
        begin
            prio_next = right_prio;
            tag_next  = right_tag;
        end
    end

    always_ff @(posedge clk)
    begin
        prio_reg <= prio_next;
        tag_reg  <= tag_next;
    end

    assign prio = prio_reg;
    assign tag  = tag_reg;

endmodule

// File: rtl/stable_priority_queue_core.sv
// Latency: the result of an item appears on the cycle after it is accepted, marked by done.
// Throughput: one item per cycle; all slots compare and shift in parallel, so busy stays low.
// Reset clears the occupancy count and the result strobe; slot contents are not cleared.
// The receiver cannot stall, and every accepted item yields exactly one result.
// Top level of the stable priority queue: count, control and a row of spq_cell slots.
// Depends on spq_pkg and spq_cell.
`timescale 1ns / 1ps
module stable_priority_queue_core
    import spq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       operation,
    input  logic signed [PRIO_W-1:0]   priority_req,
    input  logic        [TAG_W-1:0]    tag,
    output logic                       done,
    output logic        [TAG_W-1:0]    out_tag,
    output logic signed [PRIO_W-1:0]   out_priority,
    output logic        [STATUS_W-1:0] status,
    output logic        [OCC_W-1:0]    occupancy
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                done_reg;
    logic [TAG_W-1:0]    out_tag_reg;
    logic [TAG_W-1:0]    out_tag_next;
    logic [PRIO_W-1:0]   out_prio_reg;
    logic [PRIO_W-1:0]   out_prio_next;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;

    logic accept;
    logic full;
    logic empty;
    spq_ctrl_t ctrl;

    logic                     keep_w [DEPTH];
    logic signed [PRIO_W-1:0] prio_w [DEPTH];
    logic        [TAG_W-1:0]  tag_w  [DEPTH];

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = (count_reg == CNT_W'(DEPTH));
    assign empty  = (count_reg == '0);

    assign ctrl.enq  = accept && (operation == OP_ENQ) && !full;
    assign ctrl.deq  = accept && (operation == OP_DEQ) && !empty;
    assign ctrl.prio = priority_req;
    assign ctrl.tag  = tag;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic                     occ;
        logic                     l_keep;
        logic signed [PRIO_W-1:0] l_prio;
        logic        [TAG_W-1:0]  l_tag;
        logic signed [PRIO_W-1:0] r_prio;
        logic        [TAG_W-1:0]  r_tag;

        assign occ = (count_reg > CNT_W'(i));

        if (i == 0)
        begin : g_first
            assign l_keep = 1'b1;
            assign l_prio = priority_req;
            assign l_tag  = tag;
        end
        else
        begin : g_mid
            assign l_keep = keep_w[i-1];
            assign l_prio = prio_w[i-1];
            assign l_tag  = tag_w[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign r_prio = prio_w[i];
            assign r_tag  = tag_w[i];
        end
        else
        begin : g_inner
            assign r_prio = prio_w[i+1];
            assign r_tag  = tag_w[i+1];
        end

        spq_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .occupied   (occ),
            .left_keep  (l_keep),
            .left_prio  (l_prio),
            .left_tag   (l_tag),
            .right_prio (r_prio),
            .right_tag  (r_tag),
            .keep       (keep_w[i]),
            .prio       (prio_w[i]),
            .tag        (tag_w[i])
        );
    end

    always_comb
    begin
        count_next    = count_reg;
        out_tag_next  = '0;
        out_prio_next = '0;
        status_next   = ST_OK;
        if (accept)
        begin
            if (operation == OP_ENQ)
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            else
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    count_next    = count_reg - CNT_W'(1);
                    out_tag_next  = tag_w[0];
                    out_prio_next = prio_w[0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_tag_reg  <= out_tag_next;
            out_prio_reg <= out_prio_next;
            status_reg   <= status_next;
        end
    end

    assign done         = done_reg;
    assign out_tag      = out_tag_reg;
    assign out_priority = out_prio_reg;
    assign status       = status_reg;
    assign occupancy    = OCC_W'(count_reg);

endmodule

// File: rtl/spq_checker.sv
// Port-level checks for the stable priority queue, bound to the top level.
// Depends on spq_pkg and stable_priority_queue_core.
`timescale 1ns / 1ps
module spq_checker
    import spq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       done,
    input logic        [TAG_W-1:0]    out_tag,
    input logic signed [PRIO_W-1:0]   out_priority,
    input logic        [STATUS_W-1:0] status,
    input logic        [OCC_W-1:0]    occupancy
);

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done)
        else $error("Accepted item gave no result.");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |=> !done)
        else $error("Result without an accepted item.");

    a_empty_report: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_EMPTY) |-> (occupancy == '0 && out_tag == '0
            && out_priority == '0))
        else $error("Empty report with wrong fields.");

    a_full_report: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_FULL) |-> (occupancy == OCC_W'(DEPTH)
            && out_tag == '0 && out_priority == '0))
        else $error("Full report with wrong fields.");

endmodule

bind stable_priority_queue_core spq_checker #(.DEPTH(DEPTH)) u_spq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .out_tag      (out_tag),
    .out_priority (out_priority),
    .status       (status),
    .occupancy    (occupancy)
);

// File: dv/stable_priority_queue_core_test.sv
// Self-checking testbench for stable_priority_queue_core: directed and random enqueue and
// dequeue items with varied sender idling, checked against a sorted-queue predictor.
// Depends on spq_pkg and the RTL of the block.
`timescale 1ns / 1ps
module stable_priority_queue_core_test;
    import spq_pkg::*;

    localparam int STALL_LIMIT  = 4000;
    localparam int MAX_GAP      = 40;
    localparam int PHASE_ITEMS  = 295;
    localparam int REPORT_LIMIT = 10;

    typedef struct {
        logic        [TAG_W-1:0]    tag;
        logic signed [PRIO_W-1:0]   prio;
        logic        [STATUS_W-1:0] status;
        logic        [OCC_W-1:0]    occ;
    } queue_result_t;

    class sorted_queue_tracker;
        logic signed [PRIO_W-1:0] slot_prio [DEPTH_DEFAULT];
        logic        [TAG_W-1:0]  slot_tag [DEPTH_DEFAULT];
        int                       count;
        int                       mismatches;
        queue_result_t            pending_results [$];

        function new();
            count = 0;
            mismatches = 0;
        endfunction

        function void note_item(logic op, logic signed [PRIO_W-1:0] prio,
                                logic [TAG_W-1:0] tg);
            queue_result_t res;
            int            pos;
            int            i;
            res.tag = '0;
            res.prio = '0;
            res.status = ST_OK;
            if (op == OP_ENQ)
            begin
                if (count >= DEPTH_DEFAULT)
                begin
                    res.status = ST_FULL;
                end
                else
                begin
                    // Equal priorities stay in arrival order.
                    pos = 0;
                    while (pos < count && slot_prio[pos] <= prio)
                        pos++;
                    for (i = count; i > pos; i--)
                    begin
                        slot_prio[i] = slot_prio[i-1];
                        slot_tag[i] = slot_tag[i-1];
                    end
                    slot_prio[pos] = prio;
                    slot_tag[pos] = tg;
                    count++;
                end
            end
            else
            begin
                if (count == 0)
                begin
                    res.status = ST_EMPTY;
                end
                else
                begin
                    res.tag = slot_tag[0];
                    res.prio = slot_prio[0];
                    for (i = 1; i < count; i++)
                    begin
                        slot_prio[i-1] = slot_prio[i];
                        slot_tag[i-1] = slot_tag[i];
                    end
                    count--;
                end
            end
            res.occ = OCC_W'(count);
            pending_results.push_back(res);
        endfunction

        function void check_result(queue_result_t got);
            queue_result_t exp;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: result with no item pending: tag %h prio %0d status %0d occ %0d",
                             $time, got.tag, got.prio, got.status, got.occ);
                return;
            end
            exp = pending_results.pop_front();
            if (got.tag !== exp.tag || got.prio !== exp.prio
                || got.status !== exp.status || got.occ !== exp.occ)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display({"%0t: mismatch: expected tag %h prio %0d status %0d occ %0d,",
                              " got tag %h prio %0d status %0d occ %0d"},
                             $time, exp.tag, exp.prio, exp.status, exp.occ,
                             got.tag, got.prio, got.status, got.occ);
            end
        endfunction
    endclass

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    logic                       operation = OP_ENQ;
    logic signed [PRIO_W-1:0]   priority_req = '0;
    logic        [TAG_W-1:0]    tag = '0;
    logic                       done;
    logic        [TAG_W-1:0]    out_tag;
    logic signed [PRIO_W-1:0]   out_priority;
    logic        [STATUS_W-1:0] status;
    logic        [OCC_W-1:0]    occupancy;

    sorted_queue_tracker tracker = new();
    int                  stall_cycles = 0;

    stable_priority_queue_core #(
        .DEPTH(DEPTH_DEFAULT)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .operation(operation),
        .priority_req(priority_req),
        .tag(tag),
        .done(done),
        .out_tag(out_tag),
        .out_priority(out_priority),
        .status(status),
        .occupancy(occupancy)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                tracker.check_result('{out_tag, out_priority, status, occupancy});
            if (start && !busy)
                tracker.note_item(operation, priority_req, tag);
            if (done || (start && !busy))
            begin
                stall_cycles = 0;
            end
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
            else
            begin
                stall_cycles++;
            end
        end
    end

    task automatic send_item(input logic op, input logic signed [PRIO_W-1:0] prio,
                             input logic [TAG_W-1:0] tg);
        start <= 1'b1;
        operation <= op;
        priority_req <= prio;
        tag <= tg;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic hold_off(input int idle_pct);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_for_drain();
        start <= 1'b0;
        @(posedge clk);
        while (tracker.pending_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [PRIO_W-1:0] pick_priority();
        int sel;
        sel = $urandom_range(99);
        if (sel < 50)
            return PRIO_W'($signed($urandom_range(8)) - 4);
        else if (sel < 80)
            return PRIO_W'($urandom);
        case ($urandom_range(3))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'sh0000;
            default: return 16'shffff;
        endcase
    endfunction

    task automatic random_item(input int enq_pct);
        logic op;
        op = ($urandom_range(99) < enq_pct) ? OP_ENQ : OP_DEQ;
        send_item(op, pick_priority(), TAG_W'($urandom));
    endtask

    initial
    begin
        int idle_pct [4] = '{0, 72, 27, 0};
        int enq_mix [4] = '{20, 50, 80, 95};
        int enq_pct;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(OP_DEQ, 16'sh7fff, 16'hffff);
        send_item(OP_ENQ, 16'sh0000, 16'h0000);
        send_item(OP_ENQ, 16'sh7fff, 16'hffff);
        send_item(OP_ENQ, 16'sh8000, 16'h1234);
        send_item(OP_ENQ, 16'shffff, 16'haaaa);
        send_item(OP_ENQ, 16'sh0000, 16'h5555);
        send_item(OP_DEQ, 16'sh0000, 16'h0000);
        for (int i = 0; i < 12; i++)
            send_item(OP_ENQ, PRIO_W'(i % 3 - 1), TAG_W'(16'h0100 + i));
        send_item(OP_ENQ, 16'sh8000, 16'hbeef);
        for (int i = 0; i < 5; i++)
            send_item(OP_DEQ, 16'shffff, 16'hffff);
        wait_for_drain();

        enq_pct = 50;
        for (int phase = 0; phase < 4; phase++)
        begin
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n % 40 == 0)
                    enq_pct = enq_mix[$urandom_range(3)];
                random_item(enq_pct);
                hold_off(idle_pct[phase]);
            end
            wait_for_drain();
        end

        repeat (4) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.pending_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: files.f
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/stable_priority_queue_core.sv
rtl/spq_checker.sv
dv/stable_priority_queue_core_test.sv
